### rtl/core/sm3_pkg.sv
// Shared types, constants and helper functions for the SM3 compression block.
`timescale 1ns / 1ps
package sm3_pkg;

  typedef logic [31:0] word_t;

  localparam word_t SM3_T0 = 32'h79cc4519;
  localparam word_t SM3_T1 = 32'h7a879d8a;

  localparam word_t SM3_IV [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  localparam int unsigned SM3_ROUNDS = 64;

  typedef struct packed {
    logic       shift_in;
    logic       start;
    logic       use_iv;
    logic       round_en;
    logic       last_round;
    logic [5:0] round;
    logic [2:0] out_idx;
  } sm3_cmd_t;

  function automatic word_t rotl32(input word_t x, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
  endfunction

  function automatic word_t round_const(input logic [5:0] j);
    word_t t;
    t = (j[5:4] == 2'b00) ? SM3_T0 : SM3_T1;
    return rotl32(t, j[4:0]);
  endfunction

endpackage

### rtl/core/sm3_if.sv
// Valid/ready channel interfaces for message words and chaining words.
`timescale 1ns / 1ps
interface sm3_in_if import sm3_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t message_word;
  logic  new_message;
  logic  emit_digest;

  modport source(output valid, message_word, new_message, emit_digest, input ready);
  modport sink(input valid, message_word, new_message, emit_digest, output ready);
endinterface

interface sm3_out_if import sm3_pkg::*; ();
  logic       valid;
  logic       ready;
  word_t      hash_word;
  logic [2:0] word_index;
  logic       last_word;

  modport source(output valid, hash_word, word_index, last_word, input ready);
  modport sink(input valid, hash_word, word_index, last_word, output ready);
endinterface

### rtl/core/sm3_ctrl.sv
// Controller: word counting, restart flag, round sequencing and digest output.
`timescale 1ns / 1ps
module sm3_ctrl import sm3_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_new_message,
  input  logic       in_emit_digest,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_word_index,
  output logic       out_last_word,
  output sm3_cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_COMP = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [3:0] count_r, count_nxt;
  logic       pend_r, pend_nxt;
  logic       emit_r, emit_nxt;
  logic [5:0] round_r, round_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       acc;
  logic       blk_done;

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = (state_r == ST_EMIT);
  assign acc            = in_valid && in_ready;
  assign blk_done       = (count_r == 4'd15);
  assign out_word_index = idx_r;
  assign out_last_word  = (idx_r == 3'd7);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pend_nxt  = pend_r;
    emit_nxt  = emit_r;
    round_nxt = round_r;
    idx_nxt   = idx_r;

    cmd            = '0;
    cmd.round      = round_r;
    cmd.out_idx    = idx_r;
    cmd.shift_in   = acc;
    cmd.round_en   = (state_r == ST_COMP);
    cmd.last_round = (state_r == ST_COMP) && (round_r == 6'(SM3_ROUNDS - 1));

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          count_nxt = count_r + 4'd1;
          pend_nxt  = pend_r | in_new_message;
          if (blk_done) begin
            cmd.start  = 1'b1;
            cmd.use_iv = pend_r | in_new_message;
            pend_nxt   = 1'b0;
            emit_nxt   = in_emit_digest;
            round_nxt  = '0;
            state_nxt  = ST_COMP;
          end else if (in_emit_digest) begin
            idx_nxt   = '0;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_COMP: begin
        round_nxt = round_r + 6'd1;
        if (cmd.last_round) begin
          idx_nxt   = '0;
          state_nxt = emit_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (out_last_word) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
      emit_r  <= 1'b0;
      round_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      emit_r  <= emit_nxt;
      round_r <= round_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

### rtl/core/sm3_dp.sv
// Datapath: message window, expansion, one compression round per cycle, chaining value.
`timescale 1ns / 1ps
module sm3_dp import sm3_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  sm3_cmd_t cmd,
  input  word_t    in_word,
  output word_t    hash_word
);

  word_t win_r [16];
  word_t work_r [8];
  word_t cv_r [8];
  word_t rnd_nxt [8];
  word_t w_new;
  word_t a12, ss1, ss2, ffv, ggv, tt1, tt2;
  logic  early;

  assign hash_word = cv_r[cmd.out_idx];
  assign early     = (cmd.round[5:4] == 2'b00);

  assign w_new = perm1(win_r[0] ^ win_r[7] ^ rotl32(win_r[13], 5'd15))
               ^ rotl32(win_r[3], 5'd7) ^ win_r[10];

  always_comb begin
    a12 = rotl32(work_r[0], 5'd12);
    ss1 = rotl32(a12 + work_r[4] + round_const(cmd.round), 5'd7);
    ss2 = ss1 ^ a12;
    if (early) begin
      ffv = work_r[0] ^ work_r[1] ^ work_r[2];
      ggv = work_r[4] ^ work_r[5] ^ work_r[6];
    end else begin
      ffv = (work_r[0] & work_r[1]) | (work_r[0] & work_r[2]) | (work_r[1] & work_r[2]);
      ggv = (work_r[4] & work_r[5]) | (~work_r[4] & work_r[6]);
    end
    tt1 = ffv + work_r[3] + ss2 + (win_r[0] ^ win_r[4]);
    tt2 = ggv + work_r[7] + ss1 + win_r[0];
    rnd_nxt[0] = tt1;
    rnd_nxt[1] = work_r[0];
    rnd_nxt[2] = rotl32(work_r[1], 5'd9);
    rnd_nxt[3] = work_r[2];
    rnd_nxt[4] = perm0(tt2);
    rnd_nxt[5] = work_r[4];
    rnd_nxt[6] = rotl32(work_r[5], 5'd19);
    rnd_nxt[7] = work_r[6];
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_in) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= in_word;
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) begin
        work_r[i] <= cmd.use_iv ? SM3_IV[i] : cv_r[i];
      end
    end else if (cmd.round_en) begin
      for (int i = 0; i < 8; i++) begin
        work_r[i] <= rnd_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        cv_r[i] <= SM3_IV[i];
      end
    end else if (cmd.start && cmd.use_iv) begin
      for (int i = 0; i < 8; i++) begin
        cv_r[i] <= SM3_IV[i];
      end
    end else if (cmd.last_round) begin
      for (int i = 0; i < 8; i++) begin
        cv_r[i] <= cv_r[i] ^ rnd_nxt[i];
      end
    end
  end

endmodule

### rtl/core/sm3_block_compression.sv
// Top level of the SM3 block compression engine.
// A word that does not end a block leaves the input ready, unless it requests a digest.
// The sixteenth word of a block starts the 64 rounds, one round per cycle in the datapath.
// No input is taken while the rounds run or while a digest is being output.
// A digest request outputs the eight chaining words, one per accepted transfer.
// Reset (rst_n, synchronous, active low) idles the controller and loads the initial value.
`timescale 1ns / 1ps
module sm3_block_compression import sm3_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  sm3_in_if.sink   in_ch,
  sm3_out_if.source out_ch
);

  sm3_cmd_t cmd;

  sm3_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_new_message (in_ch.new_message),
    .in_emit_digest (in_ch.emit_digest),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_word_index (out_ch.word_index),
    .out_last_word  (out_ch.last_word),
    .cmd            (cmd)
  );

  sm3_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_ch.message_word),
    .hash_word (out_ch.hash_word)
  );

endmodule

### rtl/core/sm3_checker.sv
// Port-level checker for the SM3 compression engine, bound to the top level.
`timescale 1ns / 1ps
module sm3_checker import sm3_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input word_t      hash_word,
  input logic [2:0] word_index,
  input logic       last_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(hash_word) && $stable(word_index)))
    else $error("stalled result item changed");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while digest is being output");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !last_word) |=>
      (out_valid && word_index == $past(word_index) + 3'd1))
    else $error("digest word sequence broken");

  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && last_word) |=> (!out_valid && in_ready))
    else $error("output did not end after last word");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word does not match word_index");

endmodule

bind sm3_block_compression sm3_checker u_sm3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .hash_word  (out_ch.hash_word),
  .word_index (out_ch.word_index),
  .last_word  (out_ch.last_word)
);

### dv/tb.sv
// Self-checking testbench for the SM3 block compression engine.
`timescale 1ns / 1ps
module tb;
  import sm3_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned RANDOM_ITEMS = 250;

  localparam word_t T_LOW = 32'h79cc4519;
  localparam word_t T_HIGH = 32'h7a879d8a;
  localparam word_t IV_WORDS [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  typedef struct {
    word_t       w;
    bit          restart;
    bit          emit;
    int unsigned gap;
  } msg_item_t;

  typedef struct packed {
    word_t    hw;
    bit [2:0] idx;
    bit       last;
  } digest_word_t;

  logic clk;
  logic rst_n;

  sm3_in_if  in_ch();
  sm3_out_if out_ch();

  sm3_block_compression DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  msg_item_t    word_q[$];
  digest_word_t digest_q[$];

  word_t       chain [8];
  word_t       msg_buf [16];
  int unsigned fill;
  bit          reload_pending;

  int unsigned fail_count;
  int unsigned gen_fill;
  bit          steady_in;
  int unsigned in_wait;
  int unsigned out_hold;
  bit          out_steady;
  int unsigned stall_cycles;

  function automatic word_t rol(word_t x, int unsigned n);
    int unsigned s;
    s = n % 32;
    if (s == 0) return x;
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void compress_chain();
    word_t w [68];
    word_t x, t, a, b, c, d, e, f, g, h, a12, ss1, ss2, ff, gg, tt1, tt2;
    int j;
    for (j = 0; j < 16; j++) w[j] = msg_buf[j];
    for (j = 16; j < 68; j++) begin
      x = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
      w[j] = x ^ rol(x, 15) ^ rol(x, 23) ^ rol(w[j-13], 7) ^ w[j-6];
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (j = 0; j < 64; j++) begin
      t = (j < 16) ? T_LOW : T_HIGH;
      a12 = rol(a, 12);
      ss1 = rol(a12 + e + rol(t, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c;
      c = rol(b, 9);
      b = a;
      a = tt1;
      h = g;
      g = rol(f, 19);
      f = e;
      e = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
    end
    chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
    chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
  endfunction

  function automatic void absorb_word(word_t w, bit restart, bit emit);
    digest_word_t dw;
    int k;
    if (restart) reload_pending = 1'b1;
    msg_buf[fill] = w;
    fill = fill + 1;
    if (fill == 16) begin
      if (reload_pending) chain = IV_WORDS;
      reload_pending = 1'b0;
      compress_chain();
      fill = 0;
    end
    if (emit) begin
      for (k = 0; k < 8; k++) begin
        dw.hw = chain[k];
        dw.idx = k[2:0];
        dw.last = (k == 7);
        digest_q.push_back(dw);
      end
    end
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic push_item(word_t w, bit restart, bit emit);
    msg_item_t it;
    int unsigned r;
    r = $urandom_range(0, 99);
    it.w = w;
    it.restart = restart;
    it.emit = emit;
    if (steady_in || r < 60) it.gap = 0;
    else if (r < 90) it.gap = $urandom_range(1, 3);
    else it.gap = $urandom_range(8, 30);
    word_q.push_back(it);
    gen_fill = (gen_fill + 1) % 16;
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.message_word = '0;
    in_ch.new_message = 1'b0;
    in_ch.emit_digest = 1'b0;
    out_ch.ready = 1'b0;
    chain = IV_WORDS;
    fill = 0;
    reload_pending = 1'b0;
    fail_count = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    int unsigned made, nblk, blk, len;
    bit first_word, ends, restart, emit;
    gen_fill = 0;
    steady_in = 1'b1;
    // padded "abc" block as a full message
    push_item(32'h61626380, 1'b1, 1'b0);
    repeat (14) push_item(32'h00000000, 1'b0, 1'b0);
    push_item(32'h00000018, 1'b0, 1'b1);
    steady_in = 1'b0;
    push_item(32'h00000000, 1'b1, 1'b1);
    push_item(32'hffffffff, 1'b1, 1'b0);
    push_item(32'hffffffff, 1'b0, 1'b1);
    push_item(32'h00000000, 1'b0, 1'b0);
    made = 0;
    while (made < RANDOM_ITEMS) begin
      steady_in = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 15);
        repeat (len) push_item(pick_word(), $urandom_range(0, 3) == 0,
                               $urandom_range(0, 3) == 0);
        made += len;
      end else begin
        nblk = $urandom_range(1, 3);
        first_word = 1'b1;
        for (blk = 0; blk < nblk; blk++) begin
          do begin
            ends = (gen_fill == 15);
            restart = first_word || ($urandom_range(0, 49) == 0);
            if (ends && blk == nblk - 1) emit = ($urandom_range(0, 9) != 0);
            else if (ends) emit = ($urandom_range(0, 9) == 0);
            else emit = ($urandom_range(0, 29) == 0);
            push_item(pick_word(), restart, emit);
            first_word = 1'b0;
            made++;
          end while (gen_fill != 0);
        end
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (word_q.size() != 0 || in_ch.valid);
    do @(posedge clk); while (digest_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** sm3_block_compression: PASSED **");
    end else begin
      $display("** sm3_block_compression: FAILED **");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_wait <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (word_q.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (in_wait < word_q[0].gap) begin
        in_ch.valid <= 1'b0;
        in_wait <= in_wait + 1;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.message_word <= word_q[0].w;
        in_ch.new_message <= word_q[0].restart;
        in_ch.emit_digest <= word_q[0].emit;
        void'(word_q.pop_front());
        in_wait <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      absorb_word(in_ch.message_word, in_ch.new_message, in_ch.emit_digest);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_hold <= 0;
      out_steady <= 1'b0;
    end else if (out_hold != 0) begin
      out_hold <= out_hold - 1;
    end else begin
      out_steady <= ($urandom_range(0, 19) == 0) ? !out_steady : out_steady;
      if (out_steady || !out_ch.ready) begin
        out_ch.ready <= 1'b1;
        out_hold <= out_steady ? $urandom_range(0, 15) : $urandom_range(0, 7);
      end else begin
        out_ch.ready <= 1'b0;
        out_hold <= ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 2);
      end
    end
  end

  always @(posedge clk) begin
    digest_word_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.hw = out_ch.hash_word;
      got.idx = out_ch.word_index;
      got.last = out_ch.last_word;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected hash word %h index %0d last %0b",
                 $time, got.hw, got.idx, got.last);
        fail_count++;
      end else begin
        want = digest_q.pop_front();
        if (got !== want) begin
          $display("%0t: hash word mismatch: expected %h/%0d/%0b, actual %h/%0d/%0b",
                   $time, want.hw, want.idx, want.last, got.hw, got.idx, got.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
      $display("** sm3_block_compression: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
